/* design/actt_pkg.sv */
`default_nettype none
package actt_pkg;

  localparam int CODE_W   = 12;
  localparam int TEMP_W   = 19;
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int CODE_BITS_DEF   = 12;

  localparam int CHIP_ENTRIES = 35;

  // action codes
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_CONVERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRITTEN   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN = 2'd2;

  localparam logic             SORT_MODE_RST = 1'b1;
  localparam logic [CODE_W-1:0] CODE_MASK_RST = 12'hfff;
  localparam logic [LEN_W-1:0]  TABLE_LEN_RST = 7'd35;

  // factory calibration codes, zero past the end
  function automatic logic [CODE_W-1:0] chip_code(input logic [7:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      8'd0:  c = 12'd0;
      8'd1:  c = 12'd296;
      8'd2:  c = 12'd304;
      8'd3:  c = 12'd313;
      8'd4:  c = 12'd331;
      8'd5:  c = 12'd340;
      8'd6:  c = 12'd349;
      8'd7:  c = 12'd359;
      8'd8:  c = 12'd368;
      8'd9:  c = 12'd378;
      8'd10: c = 12'd388;
      8'd11: c = 12'd398;
      8'd12: c = 12'd408;
      8'd13: c = 12'd418;
      8'd14: c = 12'd429;
      8'd15: c = 12'd440;
      8'd16: c = 12'd451;
      8'd17: c = 12'd462;
      8'd18: c = 12'd473;
      8'd19: c = 12'd485;
      8'd20: c = 12'd496;
      8'd21: c = 12'd508;
      8'd22: c = 12'd521;
      8'd23: c = 12'd533;
      8'd24: c = 12'd546;
      8'd25: c = 12'd559;
      8'd26: c = 12'd572;
      8'd27: c = 12'd586;
      8'd28: c = 12'd600;
      8'd29: c = 12'd614;
      8'd30: c = 12'd629;
      8'd31: c = 12'd644;
      8'd32: c = 12'd659;
      8'd33: c = 12'd675;
      8'd34: c = 12'hfff;
      default: c = '0;
    endcase
    return c;
  endfunction

  // factory calibration temperatures in millicelsius
  function automatic logic signed [TEMP_W-1:0] chip_temp(input logic [7:0] idx);
    logic signed [TEMP_W-1:0] t;
    case (idx)
      8'd0, 8'd1: t = -19'sd40000;
      8'd2:  t = -19'sd35000;
      8'd3:  t = -19'sd30000;
      8'd4:  t = -19'sd20000;
      8'd5:  t = -19'sd15000;
      8'd6:  t = -19'sd10000;
      8'd7:  t = -19'sd5000;
      8'd8:  t = 19'sd0;
      8'd9:  t = 19'sd5000;
      8'd10: t = 19'sd10000;
      8'd11: t = 19'sd15000;
      8'd12: t = 19'sd20000;
      8'd13: t = 19'sd25000;
      8'd14: t = 19'sd30000;
      8'd15: t = 19'sd35000;
      8'd16: t = 19'sd40000;
      8'd17: t = 19'sd45000;
      8'd18: t = 19'sd50000;
      8'd19: t = 19'sd55000;
      8'd20: t = 19'sd60000;
      8'd21: t = 19'sd65000;
      8'd22: t = 19'sd70000;
      8'd23: t = 19'sd75000;
      8'd24: t = 19'sd80000;
      8'd25: t = 19'sd85000;
      8'd26: t = 19'sd90000;
      8'd27: t = 19'sd95000;
      8'd28: t = 19'sd100000;
      8'd29: t = 19'sd105000;
      8'd30: t = 19'sd110000;
      8'd31: t = 19'sd115000;
      8'd32: t = 19'sd120000;
      8'd33, 8'd34: t = 19'sd125000;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* design/adc_code_to_temperature.sv */
// flow: a write goes straight to its result; a conversion reads the range entry and rejects a
//   code below it, then binary-searches the table, each probe issuing a read and then testing
//   the pair, and a missed bracket is bad; a hit ends with a multiply and the bit-serial divider
// throughput: one item at a time; the next item is taken while the last result waits
// reset: sync active low; configuration registers take their defaults and the table reads as the factory
//   table through per-entry valid bits, so no clearing pass is needed
`default_nettype none
module adc_code_to_temperature
  import actt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int CODE_BITS   = CODE_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire  [CFG_IDX_W-1:0]       cfg_index,
  input  wire  [CODE_W-1:0]          cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_action,
  input  wire  [IDX_W-1:0]           in_entry_index,
  input  wire  [CODE_W-1:0]          in_entry_code,
  input  wire  signed [TEMP_W-1:0]   in_entry_temp,
  input  wire  [CODE_W-1:0]          in_sample_code,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [TEMP_W-1:0]   out_temperature,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IW    = AW + 1;
  localparam int CW    = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
  localparam int DW    = TEMP_W + 1;
  localparam int PW    = DW + CW;
  localparam int CNT_W = $clog2(PW);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RNG     = 9'b000000010,
    S_RNG_EV  = 9'b000000100,
    S_SRCH    = 9'b000001000,
    S_SRCH_EV = 9'b000010000,
    S_MUL     = 9'b000100000,
    S_DIV     = 9'b001000000,
    S_FIN     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic              sort_mode_r;
  logic [CODE_W-1:0] code_mask_r;
  logic [LEN_W-1:0]  table_len_r;

  // table storage
  logic [CW-1:0]            code_mem [TABLE_DEPTH];
  logic signed [TEMP_W-1:0] temp_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_r;

  logic [AW-1:0]            addr_a, addr_b;
  logic [AW-1:0]            q_addr_a_r, q_addr_b_r;
  logic [CW-1:0]            q_code_a_r, q_code_b_r;
  logic signed [TEMP_W-1:0] q_temp_a_r, q_temp_b_r;
  logic                     q_va_r, q_vb_r;
  logic [CW-1:0]            code_a, code_b;
  logic signed [TEMP_W-1:0] temp_a, temp_b;

  // datapath registers
  logic [CW-1:0]            code_r, code_nxt;
  logic [IW-1:0]            lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]            mid_r, mid_nxt;
  logic signed [TEMP_W-1:0] t_lo_r, t_lo_nxt;
  logic                     neg_r, neg_nxt;
  logic [DW-1:0]            dt_mag_r, dt_mag_nxt;
  logic [CW-1:0]            dc_r, dc_nxt, span_r, span_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [PW-1:0]            quo_r, quo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [TEMP_W-1:0] res_temp_r, res_temp_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [8:0]    tl9, n9;
  logic [IW:0]   mid_sum;
  logic [AW-1:0] mid_c;
  logic          found;
  logic          go_up;
  logic signed [DW-1:0] dt;
  logic [CW:0]          trial;
  logic                 qbit;
  logic [TEMP_W-1:0]    q19;

  assign in_ready        = (state_r == S_IDLE);
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_temperature = out_temp_r;
  assign out_status      = out_status_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_mode_r <= SORT_MODE_RST;
      code_mask_r <= CODE_MASK_RST;
      table_len_r <= TABLE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SORT_MODE: sort_mode_r <= cfg_wdata[0];
        CFG_CODE_MASK: code_mask_r <= cfg_wdata;
        CFG_TABLE_LEN: table_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // table write port and two registered read ports
  assign wr_en   = accept && (in_action == ACT_WRITE) &&
                   (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = AW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= in_entry_code[CW-1:0];
      temp_mem[wr_addr] <= in_entry_temp;
    end
    q_code_a_r <= code_mem[addr_a];
    q_temp_a_r <= temp_mem[addr_a];
    q_code_b_r <= code_mem[addr_b];
    q_temp_b_r <= temp_mem[addr_b];
    q_addr_a_r <= addr_a;
    q_addr_b_r <= addr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      q_va_r  <= 1'b0;
      q_vb_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      q_va_r <= valid_r[addr_a];
      q_vb_r <= valid_r[addr_b];
    end
  end

  // unwritten entries read as the factory table
  assign code_a = q_va_r ? q_code_a_r : CW'(chip_code(8'(q_addr_a_r)));
  assign code_b = q_vb_r ? q_code_b_r : CW'(chip_code(8'(q_addr_b_r)));
  assign temp_a = q_va_r ? q_temp_a_r : chip_temp(8'(q_addr_a_r));
  assign temp_b = q_vb_r ? q_temp_b_r : chip_temp(8'(q_addr_b_r));

  assign mid_sum = (IW+1)'(lo_r) + (IW+1)'(hi_r);
  assign mid_c   = AW'(mid_sum >> 1);
  assign addr_a  = (state_r == S_RNG) ? (sort_mode_r ? AW'(1) : hi_r[AW-1:0]) : mid_c;
  assign addr_b  = mid_c - AW'(1);

  assign tl9 = 9'(table_len_r);
  assign n9  = (tl9 < 9'd2) ? 9'd2 :
               (tl9 > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : tl9;

  // segment test on the probed pair
  always_comb begin
    if (sort_mode_r) begin
      found = (code_r <= code_a) && (code_r > code_b);
      go_up = (code_r > code_a);
    end else begin
      found = (code_r >= code_a) && (code_r < code_b);
      go_up = (code_r < code_a);
    end
  end

  assign dt    = DW'(temp_a) - DW'(temp_b);
  assign trial = {rem_r, quo_r[PW-1]};
  assign qbit  = (trial >= (CW+1)'(span_r));
  assign q19   = quo_r[TEMP_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    t_lo_nxt       = t_lo_r;
    neg_nxt        = neg_r;
    dt_mag_nxt     = dt_mag_r;
    dc_nxt         = dc_r;
    span_nxt       = span_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_temp_nxt   = res_temp_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_temp_nxt   = out_temp_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_WRITE) begin
            res_temp_nxt   = '0;
            res_status_nxt = ST_WRITTEN;
            state_nxt      = S_DONE;
          end else begin
            code_nxt  = in_sample_code[CW-1:0] & code_mask_r[CW-1:0];
            lo_nxt    = IW'(1);
            hi_nxt    = IW'(n9 - 9'd1);
            state_nxt = S_RNG;
          end
        end
      end
      S_RNG: begin
        state_nxt = S_RNG_EV;
      end
      S_RNG_EV: begin
        if (code_r < code_a) begin
          res_temp_nxt   = '0;
          res_status_nxt = ST_BAD;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r > hi_r) begin
          res_temp_nxt   = '0;
          res_status_nxt = ST_BAD;
          state_nxt      = S_DONE;
        end else begin
          mid_nxt   = mid_c;
          state_nxt = S_SRCH_EV;
        end
      end
      S_SRCH_EV: begin
        if (found) begin
          t_lo_nxt   = temp_b;
          neg_nxt    = dt[DW-1];
          dt_mag_nxt = dt[DW-1] ? DW'(-dt) : DW'(dt);
          dc_nxt     = (code_r >= code_b) ? (code_r - code_b) : (code_b - code_r);
          span_nxt   = (code_b >= code_a) ? (code_b - code_a) : (code_a - code_b);
          state_nxt  = S_MUL;
        end else begin
          if (go_up) begin
            lo_nxt = IW'(mid_r) + IW'(1);
          end else begin
            hi_nxt = IW'(mid_r) - IW'(1);
          end
          state_nxt = S_SRCH;
        end
      end
      S_MUL: begin
        if (span_r == '0) begin
          // flat segment gives its lower entry
          res_temp_nxt   = t_lo_r;
          res_status_nxt = ST_CONVERTED;
          state_nxt      = S_DONE;
        end else begin
          quo_nxt   = PW'(dt_mag_r) * PW'(dc_r);
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(PW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        rem_nxt = qbit ? CW'(trial - (CW+1)'(span_r)) : CW'(trial);
        quo_nxt = {quo_r[PW-2:0], qbit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // quotient truncates toward zero, sign comes from the temperature delta
        res_temp_nxt   = t_lo_r + (neg_r ? -$signed(q19) : $signed(q19));
        res_status_nxt = ST_CONVERTED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_temp_nxt   = res_temp_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    t_lo_r       <= t_lo_nxt;
    neg_r        <= neg_nxt;
    dt_mag_r     <= dt_mag_nxt;
    dc_r         <= dc_nxt;
    span_r       <= span_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    res_temp_r   <= res_temp_nxt;
    res_status_r <= res_status_nxt;
    out_temp_r   <= out_temp_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // a probe never reaches entry zero, so mid-1 stays in the table
  a_mid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH_EV |-> mid_r != '0)
    else $error("search probe at entry zero");

  a_div_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> span_r != '0)
    else $error("divide by zero span");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_CONVERTED |-> out_temp_r == '0)
    else $error("nonzero temperature on write or bad reading");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not moved to output");
`endif

endmodule
`default_nettype wire
